### src/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the CV channel selector
// Field widths, command and register codes, range tables and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    // parameter defaults
    localparam int CHANNELS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // field widths
    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 16;
    localparam int CV_W     = 15;
    localparam int CNT_IN_W = 5;
    localparam int TICK_W   = 10;
    localparam int RANGE_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;

    // index arithmetic
    localparam int CVD_W = CV_W + 2;   // cv minus range minimum
    localparam int T_W   = 24;         // signed rounding numerator
    localparam int REM_W = 23;         // unsigned divider remainder
    localparam int DEN_W = 16;         // twice the span
    localparam int Q_W   = 4;          // quotient bits below saturation
    localparam logic [2:0] DIV_TOP = 3'd4;

    // command codes
    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS = 1'd1;

    localparam logic [TICK_W-1:0] TICKS_RST = 10'd48;

    // voltage range codes
    localparam logic [RANGE_W-1:0] RANGE_U10  = 3'd0;
    localparam logic [RANGE_W-1:0] RANGE_U5   = 3'd1;
    localparam logic [RANGE_W-1:0] RANGE_U1   = 3'd2;
    localparam logic [RANGE_W-1:0] RANGE_B10  = 3'd3;
    localparam logic [RANGE_W-1:0] RANGE_B5   = 3'd4;
    localparam logic [RANGE_W-1:0] RANGE_B2P5 = 3'd5;
    localparam logic [RANGE_W-1:0] RANGE_B1   = 3'd6;
    localparam logic [RANGE_W-1:0] RANGE_RSVD = 3'd7;

    typedef struct packed {
        logic       store_wr;
        logic       capture;
        logic       calc;
        logic       div_step;
        logic [2:0] div_bit;
        logic       latch_sel;
        logic       emit;
        logic       lane_inc;
    } pcs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_last;
    } pcs_stat_t;

    // range minimum in mV
    function automatic logic signed [CV_W-1:0] range_min(input logic [RANGE_W-1:0] code);
        logic signed [CV_W-1:0] v;
        unique case (code) inside
            RANGE_U10, RANGE_U5, RANGE_U1, RANGE_RSVD: v = 15'sd0;
            RANGE_B10:  v = -15'sd10000;
            RANGE_B5:   v = -15'sd5000;
            RANGE_B2P5: v = -15'sd2500;
            RANGE_B1:   v = -15'sd1000;
            default:    v = 15'sd0;
        endcase
        return v;
    endfunction

    // range span in mV
    function automatic logic [CV_W-1:0] range_span(input logic [RANGE_W-1:0] code);
        logic [CV_W-1:0] v;
        unique case (code) inside
            RANGE_U10, RANGE_B5:   v = 15'd10000;
            RANGE_U5, RANGE_B2P5:  v = 15'd5000;
            RANGE_U1, RANGE_RSVD:  v = 15'd1000;
            RANGE_B10:             v = 15'd20000;
            RANGE_B1:              v = 15'd2000;
            default:               v = 15'd10000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl: sequencing state machine
// Accepts requests, runs the product / divide / select steps and paces the
// result emission against the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               command,
    input  wire pcs_pkg::pcs_stat_t stat,
    output pcs_pkg::pcs_cmd_t       cmd
);
    import pcs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] bit_reg, bit_next;

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (command == CMD_SELECT)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_CALC;
                    end
                    else
                    begin
                        cmd.store_wr = 1'b1;
                    end
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                bit_next   = DIV_TOP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_bit  = bit_reg;
                if (bit_reg == 3'd0)
                    state_next = S_SEL;
                else
                    bit_next = bit_reg - 3'd1;
            end
            S_SEL:
            begin
                cmd.latch_sel = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last)
                        state_next = S_IDLE;
                    else
                        cmd.lane_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bit_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

`default_nettype wire

### src/pcs_dp.sv
// ----------------------------------------------------------------------------
// pcs_dp: selector datapath
// Signal store, rounding product, shift-subtract divider, per-lane edge
// detectors and pulse counters, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_dp
#(
    parameter int CHANNELS    = pcs_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = pcs_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pcs_pkg::pcs_cmd_t                     cmd,
    output pcs_pkg::pcs_stat_t                         stat,
    input  wire logic [pcs_pkg::CH_W-1:0]              in_channel,
    input  wire logic signed [pcs_pkg::SAMPLE_W-1:0]   in_sample,
    input  wire logic signed [pcs_pkg::CV_W-1:0]       in_cv,
    input  wire logic [pcs_pkg::CNT_IN_W-1:0]          in_sig_ch,
    input  wire logic                                  in_poly,
    input  wire logic [pcs_pkg::CNT_IN_W-1:0]          in_cv_ch,
    input  wire logic                                  in_frame_end,
    input  wire logic [pcs_pkg::RANGE_W-1:0]           range_code,
    input  wire logic [pcs_pkg::TICK_W-1:0]            pulse_ticks,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [pcs_pkg::CH_W-1:0]                   out_channel,
    output logic                                       out_gate,
    output logic signed [pcs_pkg::SAMPLE_W-1:0]        out_sample,
    output logic                                       out_trigger,
    output logic                                       out_last
);
    import pcs_pkg::*;

    localparam int LANES = (CHANNELS < 16) ? CHANNELS : 16;
    localparam int IDX_W = $clog2(LANES);
    localparam int CNT_W = $clog2(LANES + 1);
    localparam logic [CNT_IN_W-1:0] LANE_LIM = CNT_IN_W'(LANES);

    // store, no reset
    logic signed [SAMPLE_BITS-1:0] store_reg [LANES];

    // item registers
    logic [CH_W-1:0]        ch_reg;
    logic signed [CV_W-1:0] cv_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       cvn_reg;
    logic                   poly_reg;
    logic                   fend_reg;

    // divider
    logic [REM_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [Q_W-1:0]    q_reg;
    logic              sat_reg;
    logic              neg_reg;

    logic [IDX_W-1:0]          idx_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic [IDX_W-1:0]          lane_reg;

    // lane state
    logic              seen_reg [LANES];
    logic [TICK_W-1:0] left_reg [LANES];

    // result register
    logic                       valid_reg;
    logic [CH_W-1:0]            och_reg;
    logic                       gate_reg;
    logic signed [SAMPLE_W-1:0] osamp_reg;
    logic                       trig_reg;
    logic                       last_reg;

    // ---- capture -----------------------------------------------------------
    logic                in_ch_ok;
    logic [CNT_IN_W-1:0] n_sat, cvn_sat;

    assign in_ch_ok = ({1'b0, in_channel} < LANE_LIM);
    assign n_sat    = (in_sig_ch > LANE_LIM) ? LANE_LIM : in_sig_ch;

    always_comb
    begin
        cvn_sat = (in_cv_ch > LANE_LIM) ? LANE_LIM : in_cv_ch;
        if (cvn_sat == '0)
            cvn_sat = CNT_IN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr && in_ch_ok)
            store_reg[IDX_W'(in_channel)] <= SAMPLE_BITS'(in_sample);
        if (cmd.capture)
        begin
            ch_reg   <= in_channel;
            cv_reg   <= in_cv;
            n_reg    <= CNT_W'(n_sat);
            cvn_reg  <= CNT_W'(cvn_sat);
            poly_reg <= in_poly;
            fend_reg <= in_frame_end;
        end
    end

    // ---- rounding numerator: 2*(n-1)*(cv-min) + span ----------------------
    logic [Q_W-1:0]          nm1;
    logic signed [5:0]       two_nm1;
    logic signed [CVD_W-1:0] cvd;
    logic [CV_W-1:0]         span_c;
    logic signed [T_W-1:0]   t_c;
    logic [REM_W-1:0]        den_sh;
    logic [Q_W-1:0]          idx_c;

    assign nm1     = Q_W'(n_reg - CNT_W'(1));
    assign two_nm1 = $signed({1'b0, nm1, 1'b0});
    assign span_c  = range_span(range_code);
    assign cvd     = CVD_W'(cv_reg) - CVD_W'(range_min(range_code));
    assign t_c     = T_W'(two_nm1) * T_W'(cvd) + T_W'($signed({1'b0, span_c}));
    assign den_sh  = REM_W'(den_reg) << cmd.div_bit;

    // negative numerator gives 0; saturated or too large clamps to n-1
    assign idx_c = neg_reg ? '0 : ((sat_reg || (q_reg > nm1)) ? nm1 : q_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            rem_reg <= t_c[REM_W-1:0];
            neg_reg <= t_c[T_W-1];
            den_reg <= {span_c, 1'b0};
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (cmd.div_bit == DIV_TOP)
                sat_reg <= (rem_reg >= den_sh);
            else if (rem_reg >= den_sh)
            begin
                rem_reg <= rem_reg - den_sh;
                q_reg[cmd.div_bit[1:0]] <= 1'b1;
            end
        end
        if (cmd.latch_sel)
        begin
            idx_reg  <= IDX_W'(idx_c);
            samp_reg <= SAMPLE_W'(store_reg[IDX_W'(idx_c)]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_reg <= '0;
        else if (cmd.latch_sel)
            lane_reg <= '0;
        else if (cmd.lane_inc)
            lane_reg <= lane_reg + IDX_W'(1);
    end

    // ---- per-result lane tick ----------------------------------------------
    logic                       ch_ok, n_zero;
    logic [IDX_W-1:0]           cur;
    logic                       hit, tick_en;
    logic                       seen_cur, rising, trig_c;
    logic [TICK_W-1:0]          left_cur, left_arm, left_next;
    logic                       clear_en, clear_one;
    logic [CNT_W-1:0]           clear_from;
    logic                       gate_c, last_c;
    logic [CH_W-1:0]            och_c;

    assign ch_ok  = ({1'b0, ch_reg} < LANE_LIM);
    assign n_zero = (n_reg == '0);

    always_comb
    begin
        if (poly_reg)
        begin
            cur        = IDX_W'(ch_reg);
            tick_en    = ch_ok && !n_zero;
            gate_c     = tick_en;
            last_c     = 1'b1;
            och_c      = ch_reg;
            clear_one  = ch_ok && n_zero;
            clear_en   = fend_reg;
            clear_from = n_zero ? '0 : cvn_reg;
        end
        else
        begin
            cur        = lane_reg;
            tick_en    = !n_zero;
            gate_c     = !n_zero && (lane_reg == idx_reg);
            last_c     = n_zero || (CNT_W'(lane_reg) == n_reg - CNT_W'(1));
            och_c      = n_zero ? '0 : CH_W'(lane_reg);
            clear_one  = 1'b0;
            clear_en   = 1'b1;
            clear_from = n_zero ? '0 : n_reg;
        end
    end

    assign hit       = (idx_reg == cur);
    assign seen_cur  = seen_reg[cur];
    assign left_cur  = left_reg[cur];
    assign rising    = hit && !seen_cur;
    assign left_arm  = (rising && (pulse_ticks > left_cur)) ? pulse_ticks : left_cur;
    assign trig_c    = (left_arm != '0);
    assign left_next = trig_c ? left_arm - TICK_W'(1) : left_arm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                seen_reg[i] <= 1'b1;
                left_reg[i] <= '0;
            end
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if ((clear_en && (CNT_W'(i) >= clear_from)) ||
                    (clear_one && (IDX_W'(i) == cur)))
                begin
                    seen_reg[i] <= 1'b1;
                    left_reg[i] <= '0;
                end
                else if (tick_en && (IDX_W'(i) == cur))
                begin
                    seen_reg[i] <= hit;
                    left_reg[i] <= left_next;
                end
            end
        end
    end

    // ---- result register ---------------------------------------------------
    assign stat.out_free  = !valid_reg || out_ready;
    assign stat.emit_last = last_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            och_reg   <= och_c;
            gate_reg  <= gate_c;
            osamp_reg <= gate_c ? samp_reg : '0;
            trig_reg  <= tick_en && trig_c;
            last_reg  <= last_c;
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = och_reg;
    assign out_gate    = gate_reg;
    assign out_sample  = osamp_reg;
    assign out_trigger = trig_reg;
    assign out_last    = last_reg;

    // ---- checks ------------------------------------------------------------
    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !n_zero) |-> (CNT_W'(idx_reg) < n_reg))
        else $error("selected index beyond connected channels");

    a_gate_low_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !gate_reg) |-> (osamp_reg == '0))
        else $error("sample driven on a closed gate");

endmodule

`default_nettype wire

### src/poly_cv_channel_selector_core.sv
// ----------------------------------------------------------------------------
// poly_cv_channel_selector_core: CV-addressed sequential switch
// Store requests fill a per-channel sample store; select requests map a
// control voltage to a channel and report gate, sample and trigger per lane.
// ----------------------------------------------------------------------------
// A store request (tuser = 0) produces no result. A select request
// (tuser = 1) runs capture, the rounding product 2*(n-1)*(cv-min)+span,
// five steps of the shift-subtract divider that forms the channel index,
// and the store read before its first result. Then one result leaves per
// cycle while the sink takes them, through a single output register: one
// in poly mode, n in mono mode (n capped at the lane count, one when n is
// zero). The last result of a request may still wait in the output register
// while the next request is taken. Configuration writes are accepted in
// every cycle and must only be issued while no select is in flight. Up to
// min(CHANNELS,16) lanes carry an edge detector and a pulse counter; a
// lane whose selected index rises to its own number starts a pulse of
// pulse_ticks selects.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_cv_channel_selector_core
#(
    parameter int CHANNELS    = pcs_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = pcs_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // channel[3:0] sample_value[19:4] cv_mv[34:20] signal_channels[39:35]
    // cv_poly[40] cv_channels[45:41] zero[47:46]
    input  wire logic [47:0]                       s_tdata,
    input  wire logic                              s_tlast,   // frame_end
    input  wire logic                              s_tuser,   // command
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_channel[3:0] gate[4] selected_sample[20:5] trigger[21] zero[23:22]
    output logic [23:0]                            m_tdata,
    output logic                                   m_tlast,   // last_result
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pcs_pkg::*;

    pcs_cmd_t  cmd;
    pcs_stat_t stat;

    logic [RANGE_W-1:0] range_reg;
    logic [TICK_W-1:0]  ticks_reg;

    logic [CH_W-1:0]            out_channel;
    logic                       out_gate;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_trigger;

    // configuration registers; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= RANGE_U10;
            ticks_reg <= TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RANGE: range_reg <= cfg_data[RANGE_W-1:0];
                REG_TICKS: ticks_reg <= cfg_data[TICK_W-1:0];
                default:   ;
            endcase
        end
    end

    pcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcs_dp
    #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_channel   (s_tdata[3:0]),
        .in_sample    ($signed(s_tdata[19:4])),
        .in_cv        ($signed(s_tdata[34:20])),
        .in_sig_ch    (s_tdata[39:35]),
        .in_poly      (s_tdata[40]),
        .in_cv_ch     (s_tdata[45:41]),
        .in_frame_end (s_tlast),
        .range_code   (range_reg),
        .pulse_ticks  (ticks_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_channel  (out_channel),
        .out_gate     (out_gate),
        .out_sample   (out_sample),
        .out_trigger  (out_trigger),
        .out_last     (m_tlast)
    );

    assign m_tdata = {2'b00, out_trigger, out_sample, out_gate, out_channel};

endmodule

`default_nettype wire

### dv/poly_cv_channel_selector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_cv_channel_selector_core_tb: self-checking bench of the CV selector
// Drives store and select requests plus register writes, predicts every
// lane result with its own model of the switch and compares it in order.
// ----------------------------------------------------------------------------

module poly_cv_channel_selector_core_tb;

    import pcs_pkg::*;

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 44;    // random requests per register setting
    localparam int LONG_HOLD      = 400;   // result side back-pressure stretch
    localparam int SETTLE_CYCLES  = 40;    // idle stretch after the last expected result
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
    localparam int MAX_PRINTS     = 100;

    // one request, fields as the block sees them
    typedef struct packed {
        logic                     cmd;
        logic [CH_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [CV_W-1:0]   cv;
        logic [CNT_IN_W-1:0]      sig_n;
        logic                     poly;
        logic [CNT_IN_W-1:0]      cv_n;
        logic                     frame_end;
    } request_t;

    // one lane result
    typedef struct packed {
        logic [CH_W-1:0]            out_ch;
        logic                       gate;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       trig;
        logic                       last;
    } result_t;

    // ------------------------------------------------------------------------
    // Switch predictor and result scoreboard
    // ------------------------------------------------------------------------
    class selector_scoreboard;
        logic signed [SAMPLE_W-1:0] samples [16];
        bit                         match_seen [16];
        bit [TICK_W-1:0]            pulse_left [16];
        bit [RANGE_W-1:0]           range_code;
        bit [TICK_W-1:0]            pulse_len;
        int                         min_mv [8];
        int                         span_mv [8];
        result_t                    result_q [$];
        int                         mismatches;

        function new();
            min_mv  = '{0, 0, 0, -10000, -5000, -2500, -1000, 0};
            span_mv = '{10000, 5000, 1000, 20000, 10000, 5000, 2000, 1000};
            for (int i = 0; i < 16; i++)
            begin
                samples[i] = '0;
                clear_lane(i);
            end
            range_code = RANGE_U10;
            pulse_len  = TICKS_RST;
            mismatches = 0;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_RANGE)
                range_code = data[RANGE_W-1:0];
            else
                pulse_len = data[TICK_W-1:0];
        endfunction

        function void clear_lane(int i);
            match_seen[i] = 1'b1;
            pulse_left[i] = '0;
        endfunction

        // rounded (n-1)*(cv-min)/span, halves up, clamped to 0..n-1
        function int pick_channel(int n, int cv);
            longint span, t, q;
            if (n <= 1)
                return 0;
            span = span_mv[range_code];
            t = 2 * longint'(n - 1) * longint'(cv - min_mv[range_code]) + span;
            if (t < 0)
                return 0;
            q = t / (2 * span);
            if (q > n - 1)
                q = n - 1;
            return int'(q);
        endfunction

        // edge detector and pulse counter of one lane, one call per select
        function bit lane_tick(int i, bit hit);
            bit rising;
            rising = hit && !match_seen[i];
            match_seen[i] = hit;
            if (rising && pulse_len > pulse_left[i])
                pulse_left[i] = pulse_len;
            if (pulse_left[i] != 0)
            begin
                pulse_left[i]--;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(request_t r);
            int      ch, n, cvn, idx;
            bit      hit;
            result_t e;
            ch = r.channel;
            n  = (r.sig_n > 16) ? 16 : int'(r.sig_n);
            if (r.cmd == CMD_STORE)
            begin
                samples[ch] = r.sample;
                return;
            end
            e = '0;
            e.last = 1'b1;
            if (r.poly)
            begin
                cvn = (r.cv_n > 16) ? 16 : int'(r.cv_n);
                if (cvn == 0)
                    cvn = 1;
                e.out_ch = r.channel;
                if (n == 0)
                    clear_lane(ch);
                else
                begin
                    idx      = pick_channel(n, r.cv);
                    e.gate   = 1'b1;
                    e.sample = samples[idx];
                    e.trig   = lane_tick(ch, idx == ch);
                end
                result_q.push_back(e);
                // frame end drops lanes past the output count
                if (r.frame_end)
                    for (int i = (n != 0) ? cvn : 0; i < 16; i++)
                        clear_lane(i);
                return;
            end
            // mono with nothing connected: single idle result on lane 0
            if (n == 0)
            begin
                for (int i = 0; i < 16; i++)
                    clear_lane(i);
                result_q.push_back(e);
                return;
            end
            idx = pick_channel(n, r.cv);
            for (int i = 0; i < n; i++)
            begin
                hit      = (i == idx);
                e.out_ch = CH_W'(i);
                e.gate   = hit;
                e.sample = hit ? samples[idx] : '0;
                e.trig   = lane_tick(i, hit);
                e.last   = (i == n - 1);
                result_q.push_back(e);
            end
            for (int i = n; i < 16; i++)
                clear_lane(i);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS)
                $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (result_q.size() == 0)
            begin
                report_mismatch($sformatf("result on lane %0d with none expected", got.out_ch));
                return;
            end
            want = result_q.pop_front();
            if (got.out_ch !== want.out_ch)
                report_mismatch($sformatf("lane got %0d want %0d", got.out_ch, want.out_ch));
            if (got.gate !== want.gate)
                report_mismatch($sformatf("lane %0d gate got %b want %b",
                                          want.out_ch, got.gate, want.gate));
            if (got.sample !== want.sample)
                report_mismatch($sformatf("lane %0d sample got %0d want %0d",
                                          want.out_ch, got.sample, want.sample));
            if (got.trig !== want.trig)
                report_mismatch($sformatf("lane %0d trigger got %b want %b",
                                          want.out_ch, got.trig, want.trig));
            if (got.last !== want.last)
                report_mismatch($sformatf("lane %0d last got %b want %b",
                                          want.out_ch, got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;    // channel, sample, cv, signal n, poly, cv n, zero
    logic                  s_tlast;    // frame_end
    logic                  s_tuser;    // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;    // out_channel, gate, sample, trigger, zero
    logic                  m_tlast;    // last_result
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    selector_scoreboard    sb;
    bit                    quiet;        // no idling on either side
    bit                    rx_hold_req;  // asks the result sink for a long stall
    int                    phase_items;
    logic [RANGE_W-1:0]    phase_range [PHASES];
    logic [TICK_W-1:0]     phase_ticks [PHASES];

    poly_cv_channel_selector_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request, with an optional random gap in front of it, and
    // hands it to the predictor once the block takes it. tvalid stays high
    // after acceptance so back-to-back requests need no extra assignment.
    task send_request(request_t r);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tlast  <= r.frame_end;
        s_tdata  <= {2'b00, r.cv_n, r.poly, r.sig_n, r.cv, r.sample, r.channel};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(r);
        phase_items++;
    endtask

    // store request; unused fields carry random bits
    task send_store(int ch, int value);
        request_t r;
        r.cmd       = CMD_STORE;
        r.channel   = CH_W'(ch);
        r.sample    = SAMPLE_W'(value);
        r.cv        = CV_W'($urandom);
        r.sig_n     = CNT_IN_W'($urandom);
        r.poly      = 1'($urandom);
        r.cv_n      = CNT_IN_W'($urandom);
        r.frame_end = 1'($urandom);
        send_request(r);
    endtask

    task send_select(bit poly, int ch, int cv, int n, int cvn, bit fe);
        request_t r;
        r.cmd       = CMD_SELECT;
        r.channel   = CH_W'(ch);
        r.sample    = SAMPLE_W'($urandom);
        r.cv        = CV_W'(cv);
        r.sig_n     = CNT_IN_W'(n);
        r.poly      = poly;
        r.cv_n      = CNT_IN_W'(cvn);
        r.frame_end = fe;
        send_request(r);
    endtask

    // Sender stops and waits for every expected result; the extra cycles
    // cover a store still in flight behind the last result.
    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes both registers back to back, only ever called after drain()
    task configure(logic [RANGE_W-1:0] range_code, logic [TICK_W-1:0] ticks);
        logic [CFG_IDX_W-1:0]  idx [2];
        logic [CFG_DATA_W-1:0] data [2];
        idx[0]  = REG_RANGE;
        data[0] = CFG_DATA_W'(range_code);
        idx[1]  = REG_TICKS;
        data[1] = ticks;
        for (int k = 0; k < 2; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= data[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_register(idx[k], data[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly around the active range so the index walks across lanes,
    // now and then anywhere in the 15-bit field
    function automatic int random_cv();
        logic signed [CV_W-1:0] raw;
        int                     lo;
        int                     span;
        raw = CV_W'($urandom);
        if ($urandom_range(0, 4) == 0)
            return raw;
        span = sb.span_mv[sb.range_code];
        lo   = sb.min_mv[sb.range_code] - span / 8;
        return lo + int'($urandom_range(0, span + span / 4));
    endfunction

    // connected channel count, occasionally zero or past the lane limit
    function automatic int random_lanes();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 31);
        return $urandom_range(1, 16);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: checks every accepted result and throttles tready.
    // A long hold is counted here while the sender keeps offering requests.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int      stall_left;
        result_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.out_ch = m_tdata[3:0];
                got.gate   = m_tdata[4];
                got.sample = m_tdata[20:5];
                got.trig   = m_tdata[21];
                got.last   = m_tlast;
                sb.check_result(got);
            end
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall_left  = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // no handshake of any kind for too long means the block hung
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else if (rst_n)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int kind;
        int len;
        int n;
        int cvn;
        int cvf;
        int value;
        bit paused;

        sb          = new();
        quiet       = 1'b0;
        rx_hold_req = 1'b0;
        paused      = 1'b0;
        phase_items = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = CMD_STORE;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_RANGE;
        cfg_data    = '0;

        // every range code once, pulse lengths from zero to the maximum;
        // the final setting runs with no idling at all
        phase_range = '{RANGE_U10, RANGE_B10, RANGE_U5, RANGE_B5,
                        RANGE_U1, RANGE_B2P5, RANGE_B1, RANGE_RSVD};
        phase_ticks = '{10'd3, 10'd1, 10'd0, 10'd1023, 10'd7, 10'd2, 10'd20, 10'd5};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole store first so no select ever reads an unwritten
        // entry; the values cover both sample extremes and alternating bit patterns.
        for (int c = 0; c < 16; c++)
        begin
            case (c)
                0:       value = -32768;
                1:       value = 32767;
                2:       value = 0;
                3:       value = -1;
                4:       value = 16'h5555;
                5:       value = 16'hAAAA;
                default: value = $urandom_range(0, 16'hFFFF);
            endcase
            send_store(c, value);
        end

        // directed selects under the reset settings (0..10 V, 48 ticks)
        send_select(1'b0, 0, 10000, 16, 1, 1'b0);    // top of range, last lane
        send_select(1'b0, 9, 0, 16, 1, 1'b0);        // bottom, lane 0 edge
        send_select(1'b0, 0, -16384, 16, 1, 1'b0);   // far below minimum
        send_select(1'b0, 15, 16383, 16, 1, 1'b1);   // far above, mono frame end
        send_select(1'b0, 0, 5000, 0, 1, 1'b0);      // mono, nothing connected
        send_select(1'b0, 0, 5000, 31, 1, 1'b0);     // channel count saturates
        send_select(1'b0, 0, 7000, 1, 1, 1'b0);      // single channel
        send_select(1'b0, 0, 2500, 3, 1, 1'b0);      // exact half rounds up
        send_select(1'b0, 0, 2499, 3, 1, 1'b0);      // just below half
        send_select(1'b1, 0, 0, 0, 1, 1'b0);         // poly, nothing connected
        send_select(1'b1, 15, 10000, 16, 31, 1'b0);  // poly top lane, cv count saturates
        send_select(1'b1, 0, 0, 4, 0, 1'b1);         // cv count zero, frame end
        send_select(1'b1, 3, 6000, 0, 16, 1'b1);     // frame end with no signals

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            configure(phase_range[phase], phase_ticks[phase]);
            quiet       = (phase == PHASES - 1);
            phase_items = 0;
            paused      = 1'b0;
            // sink stalls for a long stretch while requests keep coming
            if (phase == 2)
                rx_hold_req = 1'b1;
            while (phase_items < PHASE_ITEMS)
            begin
                // sender holds off once until the pipe is empty
                if (phase == 4 && !paused && phase_items >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1:
                    begin
                        len = $urandom_range(1, 4);
                        for (int k = 0; k < len; k++)
                            send_store($urandom_range(0, 15), $urandom_range(0, 16'hFFFF));
                    end
                    2, 3, 4:
                    begin
                        // well-formed poly frame, lanes in order, frame end last
                        cvn = $urandom_range(1, 16);
                        cvf = cvn;
                        if (cvn == 1 && $urandom_range(0, 1) == 0)
                            cvf = 0;
                        if (cvn == 16 && $urandom_range(0, 1) == 0)
                            cvf = $urandom_range(16, 31);
                        n = random_lanes();
                        for (int c = 0; c < cvn; c++)
                            send_select(1'b1, c, random_cv(), n, cvf, c == cvn - 1);
                    end
                    5, 6, 7:
                        send_select(1'b0, $urandom_range(0, 15), random_cv(), random_lanes(),
                                    $urandom_range(0, 31), 1'($urandom));
                    8:
                    begin
                        // broken frame: lanes out of order, stray frame ends
                        len = $urandom_range(1, 6);
                        n   = random_lanes();
                        for (int k = 0; k < len; k++)
                            send_select(1'b1, $urandom_range(0, 15), random_cv(), n,
                                        $urandom_range(0, 31), $urandom_range(0, 3) == 0);
                    end
                    default:
                        send_select(1'($urandom), $urandom_range(0, 15),
                                    int'(CV_W'($urandom)), $urandom_range(0, 31),
                                    $urandom_range(0, 31), 1'($urandom));
                endcase
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
